// ===== rtl/sdkt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdkt_pkg
// Shared types and constants for the sorted descending key table.
// ----------------------------------------------------------------------------
package sdkt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam int KEY_WIDTH           = 34;
   localparam int PAYLOAD_WIDTH       = 32;
   localparam int MODE_WIDTH          = 2;
   localparam int COUNT_OUT_WIDTH     = 5;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]    mode;
      logic [KEY_WIDTH-1:0]     key;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } req_type;

   typedef struct packed {
      logic                       ok;
      logic                       found;
      logic [PAYLOAD_WIDTH-1:0]   payload_out;
      logic [COUNT_OUT_WIDTH-1:0] entry_count;
   } rsp_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_UPDATE = 1'b1
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;  // latch the request and the per-slot compare results
      logic commit;   // apply the operation to the table and issue the result
   } dp_cmd_type;

endpackage : sdkt_pkg

// ===== rtl/sdkt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdkt_ctrl
// Two-state controller: accepts a transaction, then commits it.
// ----------------------------------------------------------------------------
module sdkt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output sdkt_pkg::dp_cmd_type   cmd
);
   import sdkt_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      busy        = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
            if (start) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            busy       = 1'b1;
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : sdkt_ctrl

// ===== rtl/sdkt_datapath.sv =====
// ----------------------------------------------------------------------------
// sdkt_datapath
// Register table of keys and payloads with per-slot compare and shift cells.
// ----------------------------------------------------------------------------
module sdkt_datapath #(
   parameter int TABLE_DEPTH = sdkt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sdkt_pkg::dp_cmd_type cmd,
   input  sdkt_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output sdkt_pkg::rsp_type    rsp_data
);
   import sdkt_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [KEY_WIDTH-1:0]     key_ff [TABLE_DEPTH];
   logic [KEY_WIDTH-1:0]     key_in [TABLE_DEPTH];
   logic [PAYLOAD_WIDTH-1:0] pay_ff [TABLE_DEPTH];
   logic [PAYLOAD_WIDTH-1:0] pay_in [TABLE_DEPTH];
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   req_type                  req_ff;
   logic [TABLE_DEPTH-1:0]   gtv_ff;
   logic [TABLE_DEPTH-1:0]   gtv_in;
   logic [TABLE_DEPTH-1:0]   match_ff;
   logic [TABLE_DEPTH-1:0]   match_in;
   logic [TABLE_DEPTH-1:0]   slot_valid;
   logic [TABLE_DEPTH-1:0]   ins_here;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   logic                     found;
   logic                     full;
   logic                     insert_do;
   logic                     remove_do;
   logic [PAYLOAD_WIDTH-1:0] hit_payload;

   // Slot validity and the compare of the incoming key against every slot.
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_valid[i] = CW'(i) < count_ff;
         gtv_in[i]     = slot_valid[i] && (key_ff[i] > req_data.key);
         match_in[i]   = slot_valid[i] && (key_ff[i] == req_data.key);
      end
   end

   assign found     = |match_ff;
   assign full      = count_ff == CW'(TABLE_DEPTH);
   assign insert_do = (req_ff.mode == MODE_INSERT) && !found && !full;
   assign remove_do = (req_ff.mode == MODE_REMOVE) && found;

   // The insert position is the first slot not holding a larger key.
   assign ins_here[0] = !gtv_ff[0];

   genvar g;
   generate
      for (g = 1; g < TABLE_DEPTH; g++) begin : g_ins
         assign ins_here[g] = !gtv_ff[g] && gtv_ff[g-1];
      end

      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         always_comb begin
            key_in[g] = key_ff[g];
            pay_in[g] = pay_ff[g];
            if (insert_do) begin
               if (ins_here[g]) begin
                  key_in[g] = req_ff.key;
                  pay_in[g] = req_ff.payload;
               end else if (g > 0) begin
                  if (slot_valid[(g > 0) ? g - 1 : 0] && !gtv_ff[(g > 0) ? g - 1 : 0]) begin
                     key_in[g] = key_ff[(g > 0) ? g - 1 : 0];
                     pay_in[g] = pay_ff[(g > 0) ? g - 1 : 0];
                  end
               end
            end else if (remove_do) begin
               if (g < TABLE_DEPTH - 1) begin
                  if (slot_valid[g] && !gtv_ff[g]) begin
                     key_in[g] = key_ff[(g < TABLE_DEPTH - 1) ? g + 1 : g];
                     pay_in[g] = pay_ff[(g < TABLE_DEPTH - 1) ? g + 1 : g];
                  end
               end
            end
         end
      end
   endgenerate

   // Payload of the matching slot; at most one slot can match.
   always_comb begin
      hit_payload = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_payload = hit_payload | (match_ff[i] ? pay_ff[i] : '0);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (req_ff.mode == MODE_CLEAR) begin
         count_in = '0;
      end else if (insert_do) begin
         count_in = count_ff + CW'(1);
      end else if (remove_do) begin
         count_in = count_ff - CW'(1);
      end
      rsp_in.ok          = insert_do || remove_do || (req_ff.mode == MODE_CLEAR);
      rsp_in.found       = found && (req_ff.mode != MODE_CLEAR);
      rsp_in.payload_out = (req_ff.mode == MODE_SEARCH) ? hit_payload : '0;
      rsp_in.entry_count = COUNT_OUT_WIDTH'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff   <= req_data;
         gtv_ff   <= gtv_in;
         match_ff <= match_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            key_ff[i] <= key_in[i];
            pay_ff[i] <= pay_in[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : sdkt_datapath

// ===== rtl/sorted_descending_key_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_descending_key_table_core
// Fixed-capacity table of unique keys kept in descending order, with payloads.
// ----------------------------------------------------------------------------
// Usage. A transaction is offered on req_data with start held high; it is
// taken at the rising edge where start is high and busy is low. The request
// carries a mode (insert, remove, search or clear), a 34-bit key and a
// 32-bit payload that is only stored by an insert.
// In the cycle of acceptance every occupied slot compares its key with the
// request key in parallel, and those compare results are registered. The
// next cycle, while busy is high, each slot takes its own, its neighbour's
// or the new entry, so the table shifts in a single step.
// Every transaction returns exactly one result: rsp_valid rises at the edge
// after the accepting edge and stays high for one cycle, so the result is
// taken while rsp_valid is high, with ok, found, payload_out and entry_count
// on rsp_data. The receiver cannot hold a result off; the result register
// is written only once per transaction, so nothing is lost.
// A transaction has a compare phase followed by a table update phase, and
// no new request is taken during the update, while busy is high; a new
// request may be taken in the same cycle that the previous result is shown.
// Reset is synchronous and active high: it empties the table at once by
// clearing the entry count. Slot contents are not cleared, as only slots
// below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_descending_key_table_core #(
   parameter int TABLE_DEPTH = sdkt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sdkt_pkg::req_type req_data,
   output logic              rsp_valid,
   output sdkt_pkg::rsp_type rsp_data
);
   import sdkt_pkg::*;

   // Command bundle from the controller to the datapath.
   dp_cmd_type dp_cmd;

   // The controller only sequences the two phases of a transaction.
   sdkt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (dp_cmd)
   );

   // The datapath holds the table, the entry count and the result register.
   sdkt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule : sorted_descending_key_table_core

// ===== rtl/sdkt_checker.sv =====
// ----------------------------------------------------------------------------
// sdkt_checker
// Port-level checks on the sorted descending key table, bound to the top.
// ----------------------------------------------------------------------------
module sdkt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input sdkt_pkg::rsp_type rsp_data
);
   import sdkt_pkg::*;

   // An accepted transaction makes the block busy for exactly one cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 !busy)
      else $error("busy did not span exactly one cycle after acceptance");

   // Each accepted transaction yields its result, registered into rsp_valid from the update state.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("result missing two cycles after acceptance");

   // A result only ever appears after a matching acceptance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start, 2) && !$past(busy, 2)))
      else $error("result without a matching transaction");

   // A non-zero payload is returned only by a search that found its key.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.payload_out != '0)) |-> (rsp_data.found && !rsp_data.ok))
      else $error("payload returned for something other than a search hit");

endmodule : sdkt_checker

bind sorted_descending_key_table_core sdkt_checker u_sdkt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
